// ===== rtl/core/gbp_pkg.sv =====
// Package for the graph BFS path engine.
// Request and result types and status codes; no dependencies.
package gbp_pkg;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_PATH    = 3'd1;
  localparam logic [2:0] ST_NOPATH  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_SAME    = 3'd4;
  localparam logic [2:0] ST_DUP     = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_PATH = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] label_a;
    logic signed [15:0] label_b;
  } gbp_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] vertex_label;
    logic [4:0]         hop_index;
    logic               last;
  } gbp_res_t;

endpackage

// ===== rtl/core/gbp_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/graph_bfs_path_engine_top.sv =====
// Graph BFS path engine. Requests add undirected edges or ask for the shortest
// path between two labels. Edges are kept in an adjacency-row RAM, labels in a
// slot RAM, BFS parents, the queue and the path trail in three more RAMs. After
// reset a clearing pass zeros the adjacency RAM before any request is taken.
// The label lookup reads one slot per cycle over the current vertex count. An
// add request then inserts new labels and updates both adjacency rows, unless
// the edge is a duplicate or the table is full. A path request runs BFS after
// the lookup. Each dequeued vertex goes through a dequeue, a row read, a scan
// of every known vertex and a wait to settle the next queue read. The trace
// writes the trail and reads the parent of each path vertex in turn, and each
// path result then fetches its trail slot and its label and loads the output
// register, waiting while the receiver stalls. One request is handled at a time;
// a new request is taken once the last result has left the output register.
module graph_bfs_path_engine_top #(
  parameter int MAX_NODES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbp_pkg::gbp_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gbp_pkg::gbp_res_t out_data
);
  import gbp_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_ADD0  = 4'd3;
  localparam logic [3:0] S_ADD1  = 4'd4;
  localparam logic [3:0] S_ADD2  = 4'd5;
  localparam logic [3:0] S_DEQ   = 4'd6;
  localparam logic [3:0] S_ROW   = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_TRACE = 4'd9;
  localparam logic [3:0] S_TWAIT = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_ELAB  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [3:0] S_QWAIT = 4'd14;

  logic [3:0]           state;
  gbp_req_t             req;
  logic [CW-1:0]        vcount;
  logic [CW-1:0]        idx;
  logic                 lk_phase;
  logic                 fa, fb;
  logic [AW-1:0]        sa, sb;
  logic [MAX_NODES-1:0] visited;
  logic [CW-1:0]        qhead, qtail;
  logic [AW-1:0]        cur;
  logic [MAX_NODES-1:0] row;
  logic [CW-1:0]        plen;
  logic [AW-1:0]        tv;
  logic [CW-1:0]        ei;
  logic                 res_pending;
  gbp_res_t             res;

  // RAM ports.
  logic                 adj_we, lab_we, par_we, q_we, tr_we;
  logic [AW-1:0]        adj_wa, adj_ra, lab_wa, lab_ra, par_wa, par_ra, q_wa, q_ra;
  logic [AW-1:0]        tr_wa, tr_ra;
  logic [MAX_NODES-1:0] adj_wd, adj_rd;
  logic [15:0]          lab_wd, lab_rd;
  logic [AW-1:0]        par_wd, par_rd, q_wd, q_rd, tr_wd, tr_rd;

  gbp_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd));
  gbp_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_lab (
    .clk(clk), .we(lab_we), .waddr(lab_wa), .wdata(lab_wd), .raddr(lab_ra), .rdata(lab_rd));
  gbp_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_par (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
  gbp_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_q (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
  gbp_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_tr (
    .clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd));

  assign in_ready  = (state == S_IDLE) && !res_pending;
  assign out_valid = res_pending;
  assign out_data  = res;

  logic [AW-1:0] idx_a, scan_j;
  logic [CW-1:0] need;
  logic          nb_hit;
  logic [CW-1:0] lk_prev;
  logic [AW-1:0] deq_v;
  assign idx_a   = idx[AW-1:0];
  assign scan_j  = idx[AW-1:0];
  assign need    = CW'(!fa) + CW'(!fb);
  assign lk_prev = idx - CW'(1);
  assign nb_hit  = row[scan_j] && !visited[scan_j];
  // The start vertex heads the queue without being stored in it.
  assign deq_v   = (qhead == '0) ? sa : q_rd;

  // Memory address and write selection per state.
  always_comb begin
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_ra = '0;
    lab_we = 1'b0; lab_wa = vcount[AW-1:0]; lab_wd = '0; lab_ra = idx_a;
    par_we = 1'b0; par_wa = scan_j; par_wd = cur; par_ra = tv;
    q_we = 1'b0; q_wa = qtail[AW-1:0]; q_wd = scan_j; q_ra = qhead[AW-1:0];
    tr_we = 1'b0; tr_wa = plen[AW-1:0]; tr_wd = tv;
    tr_ra = AW'(plen - CW'(1) - ei);
    case (state)
      S_CLR: begin
        adj_we = 1'b1; adj_wa = idx_a;
      end
      S_ADD0: begin
        adj_ra = sa;
        lab_we = !fa; lab_wd = req.label_a;
      end
      S_ADD1: begin
        // A new slot has a cleared row, so its stale read is ignored.
        adj_ra = sb;
        adj_we = 1'b1; adj_wa = sa;
        adj_wd = (fa ? adj_rd : '0) | (MAX_NODES'(1) << sb);
        lab_we = !fb; lab_wa = sb; lab_wd = req.label_b;
      end
      S_ADD2: begin
        adj_we = 1'b1; adj_wa = sb; adj_wd = adj_rd | (MAX_NODES'(1) << sa);
      end
      S_DEQ: begin
        adj_ra = deq_v;
      end
      S_SCAN: begin
        par_we = nb_hit;
        q_we   = nb_hit && (qtail < CW'(MAX_NODES));
      end
      S_TRACE: begin
        tr_we = 1'b1;
      end
      S_EMIT, S_ELAB, S_OUT: begin
        lab_ra = tr_rd;
      end
      default: begin
      end
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      idx         <= '0;
      vcount      <= '0;
      res_pending <= 1'b0;
      visited     <= '0;
    end else begin
      if (res_pending && out_ready) begin
        res_pending <= 1'b0;
      end
      case (state)
        S_CLR: begin
          idx <= idx + CW'(1);
          if (idx == CW'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req      <= in_data;
            idx      <= '0;
            lk_phase <= 1'b0;
            fa       <= 1'b0;
            fb       <= 1'b0;
            state    <= S_LOOK;
            if (in_data.req_type == REQ_ADD && in_data.label_a == in_data.label_b) begin
              res         <= '{ST_SAME, 16'sd0, 5'd0, 1'b1};
              res_pending <= 1'b1;
              state       <= S_IDLE;
            end
          end
        end
        S_LOOK: begin
          // Label lookup: one slot read per cycle, compared in the next cycle.
          if (lk_phase) begin
            if (!fa && lab_rd == req.label_a) begin
              fa <= 1'b1; sa <= lk_prev[AW-1:0];
            end
            if (!fb && lab_rd == req.label_b) begin
              fb <= 1'b1; sb <= lk_prev[AW-1:0];
            end
          end
          if (idx < vcount) begin
            idx      <= idx + CW'(1);
            lk_phase <= 1'b1;
          end else begin
            lk_phase <= 1'b0;
            if (lk_phase) begin
              // Last compare is still pending this cycle; finish next cycle.
              idx <= idx;
            end else if (req.req_type == REQ_ADD) begin
              if (fa && fb) begin
                state <= S_ADD0;
              end else if (vcount + need > CW'(MAX_NODES)) begin
                res <= '{ST_FULL, 16'sd0, 5'd0, 1'b1};
                res_pending <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_ADD0;
              end
            end else begin
              if (!fa || !fb) begin
                res <= '{ST_UNKNOWN, 16'sd0, 5'd0, 1'b1};
                res_pending <= 1'b1;
                state <= S_IDLE;
              end else if (sa == sb) begin
                res <= '{ST_SAME, 16'sd0, 5'd0, 1'b1};
                res_pending <= 1'b1;
                state <= S_IDLE;
              end else begin
                visited <= MAX_NODES'(1) << sa;
                qhead   <= '0;
                qtail   <= CW'(1);
                state   <= S_DEQ;
              end
            end
          end
        end
        S_ADD0: begin
          // Insert an unknown label_a and assign slots to unknown labels; the row of a new slot is still clear.
          state <= S_ADD1;
        end
        S_ADD1: begin
          if (fa && fb && adj_rd[sb]) begin
            state <= S_IDLE;
            res <= '{ST_DUP, 16'sd0, 5'd0, 1'b1};
            res_pending <= 1'b1;
          end else begin
            state <= S_ADD2;
          end
        end
        S_ADD2: begin
          res <= '{ST_ADDED, 16'sd0, 5'd0, 1'b1};
          res_pending <= 1'b1;
          state <= S_IDLE;
        end
        S_DEQ: begin
          if (qhead >= qtail) begin
            res <= '{ST_NOPATH, 16'sd0, 5'd0, 1'b1};
            res_pending <= 1'b1;
            state <= S_IDLE;
          end else if (deq_v == sb) begin
            tv    <= sb;
            plen  <= '0;
            state <= S_TRACE;
          end else begin
            cur   <= deq_v;
            qhead <= qhead + CW'(1);
            state <= S_ROW;
          end
        end
        S_ROW: begin
          row   <= adj_rd;
          idx   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (nb_hit && idx < vcount) begin
            visited[scan_j] <= 1'b1;
            if (qtail < CW'(MAX_NODES)) begin
              qtail <= qtail + CW'(1);
            end
          end
          if (idx >= vcount - CW'(1) || idx == CW'(MAX_NODES - 1)) begin
            state <= S_QWAIT;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_QWAIT: begin
          // Queue read issued after the last enqueue has landed.
          state <= S_DEQ;
        end
        S_TRACE: begin
          plen <= plen + CW'(1);
          if (tv == sa || plen == CW'(MAX_NODES - 1)) begin
            ei    <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_TWAIT;
          end
        end
        S_TWAIT: begin
          tv    <= par_rd;
          state <= S_TRACE;
        end
        S_EMIT: begin
          // Trail RAM read is issued; its slot addresses the label read next.
          if (!res_pending || out_ready) begin
            state <= S_ELAB;
          end
        end
        S_ELAB: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_pending) begin
            res.status       <= ST_PATH;
            res.vertex_label <= lab_rd;
            res.hop_index    <= 5'(ei);
            res.last         <= (ei + CW'(1) == plen);
            res_pending      <= 1'b1;
            ei               <= ei + CW'(1);
            state            <= (ei + CW'(1) == plen) ? S_IDLE : S_EMIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (state == S_ADD0) begin
        if (!fa) begin
          sa <= vcount[AW-1:0];
        end
        if (!fb) begin
          sb <= AW'(vcount + CW'(!fa));
        end
        vcount <= vcount + need;
      end
    end
  end

endmodule

// ===== test/gbp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the graph BFS path engine: watches both channels, predicts the
// results of each accepted request and compares them. Depends on gbp_pkg.
module gbp_checker #(
  parameter int MAX_NODES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  gbp_pkg::gbp_req_t in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  gbp_pkg::gbp_res_t out_data,
  output int                errors,
  output int                pending
);
  import gbp_pkg::*;

  // Shadow graph state.
  logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
  logic [15:0]          slot_lbl [MAX_NODES];
  int                   node_cnt;
  gbp_res_t             exp_results [$];

  assign pending = exp_results.size();

  function automatic int find_slot(logic [15:0] lbl);
    for (int i = 0; i < node_cnt; i++)
      if (slot_lbl[i] == lbl) return i;
    return -1;
  endfunction

  function automatic gbp_res_t status_only(logic [2:0] st);
    gbp_res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Work out the results of one request and update the shadow graph.
  task automatic predict_request(gbp_req_t rq);
    int sa, sb, need, head, tail, cur, len, v;
    int par [MAX_NODES];
    int bfs_q [MAX_NODES];
    int trail [MAX_NODES];
    logic [MAX_NODES-1:0] seen;
    logic found;
    gbp_res_t r;
    sa = find_slot(rq.label_a);
    sb = find_slot(rq.label_b);
    if (rq.req_type == REQ_ADD) begin
      if (rq.label_a == rq.label_b) begin
        exp_results.push_back(status_only(ST_SAME));
      end else if (sa >= 0 && sb >= 0 && adj_rows[sa][sb]) begin
        exp_results.push_back(status_only(ST_DUP));
      end else begin
        need = (sa < 0) + (sb < 0);
        if (node_cnt + need > MAX_NODES) begin
          exp_results.push_back(status_only(ST_FULL));
        end else begin
          if (sa < 0) begin
            slot_lbl[node_cnt] = rq.label_a;
            sa = node_cnt++;
          end
          if (sb < 0) begin
            slot_lbl[node_cnt] = rq.label_b;
            sb = node_cnt++;
          end
          adj_rows[sa][sb] = 1'b1;
          adj_rows[sb][sa] = 1'b1;
          exp_results.push_back(status_only(ST_ADDED));
        end
      end
    end else if (sa < 0 || sb < 0) begin
      exp_results.push_back(status_only(ST_UNKNOWN));
    end else if (sa == sb) begin
      exp_results.push_back(status_only(ST_SAME));
    end else begin
      // Breadth-first search, neighbors in ascending slot order.
      seen = '0;
      seen[sa] = 1'b1;
      head = 0;
      tail = 0;
      found = 1'b0;
      bfs_q[tail++] = sa;
      while (head < tail && !found) begin
        cur = bfs_q[head++];
        if (cur == sb) begin
          found = 1'b1;
        end else begin
          for (int j = 0; j < node_cnt; j++)
            if (adj_rows[cur][j] && !seen[j]) begin
              seen[j] = 1'b1;
              par[j] = cur;
              if (tail < MAX_NODES) bfs_q[tail++] = j;
            end
        end
      end
      if (!found) begin
        exp_results.push_back(status_only(ST_NOPATH));
      end else begin
        len = 0;
        v = sb;
        while (len < MAX_NODES) begin
          trail[len++] = v;
          if (v == sa) break;
          v = par[v];
        end
        for (int i = 0; i < len; i++) begin
          r.status = ST_PATH;
          r.vertex_label = slot_lbl[trail[len-1-i]];
          r.hop_index = 5'(i);
          r.last = (i + 1 == len);
          exp_results.push_back(r);
        end
      end
    end
  endtask

  // Sample both channels at the clock edge and compare.
  always @(posedge clk) begin
    gbp_res_t e;
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) adj_rows[i] = '0;
      node_cnt = 0;
      errors = 0;
      exp_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (exp_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result %p", out_data);
        end else begin
          e = exp_results.pop_front();
          if (e.status !== out_data.status || e.vertex_label !== out_data.vertex_label ||
              e.hop_index !== out_data.hop_index || e.last !== out_data.last) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
      if (in_valid && in_ready) predict_request(in_data);
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the graph BFS path engine: drives requests and gives the
// verdict. Depends on gbp_pkg, graph_bfs_path_engine_top and gbp_checker.
module tb_top;
  import gbp_pkg::*;

  localparam int WATCHDOG = 20000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  gbp_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gbp_res_t out_data;
  int       errors;
  int       pending;
  int       idle_cycles = 0;
  logic     timed_out = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  graph_bfs_path_engine_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  gbp_checker i_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .errors(errors), .pending(pending)
  );

  // Receiver stalls: stretches of always ready alternate with random stalls.
  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 400) % 3);
    if (rst) out_ready <= 1'b0;
    else if (phase == 0) out_ready <= 1'b1;
    else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 4) == 0);
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one request and wait for its acceptance.
  task automatic send_request(logic rt, logic [15:0] la, logic [15:0] lb);
    in_data <= '{req_type: rt, label_a: la, label_b: lb};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and idle for a random gap, at burst ends.
  task automatic maybe_gap(ref int burst);
    if (--burst <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst = $urandom_range(1, 8);
    end
  endtask

  function automatic logic [15:0] pick_label(int pool);
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(pool + $urandom_range(0, 11));
  endfunction

  initial begin
    int burst;
    int base;
    logic [15:0] ends [4];
    burst = 4;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty graph, extremes, self loop, duplicate, same ends, no path.
    send_request(REQ_PATH, 16'h0001, 16'h0002);
    send_request(REQ_ADD, 16'h8000, 16'h7FFF);
    send_request(REQ_ADD, 16'hFFFF, 16'hFFFF);
    send_request(REQ_ADD, 16'h7FFF, 16'h8000);
    send_request(REQ_ADD, 16'h7FFF, 16'h0000);
    send_request(REQ_PATH, 16'h8000, 16'h0000);
    send_request(REQ_PATH, 16'h0000, 16'h0000);
    send_request(REQ_ADD, 16'h5555, 16'hAAAA);
    send_request(REQ_PATH, 16'h8000, 16'h5555);
    send_request(REQ_PATH, 16'h8000, 16'h1234);
    // Long chain that runs into the vertex table limit, then overflow.
    for (int i = 0; i < 28; i++) send_request(REQ_ADD, 16'(100 + i), 16'(101 + i));
    send_request(REQ_PATH, 16'd100, 16'd128);
    send_request(REQ_ADD, 16'd900, 16'd901);
    send_request(REQ_ADD, 16'd100, 16'd901);
    send_request(REQ_PATH, 16'd128, 16'd100);

    // Pause until every expected result has arrived.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    // Random: mostly well-formed requests on a small label pool.
    base = 16'h4000;
    for (int n = 0; n < 60; n++) begin
      if (n % 25 == 0) base = $urandom_range(0, 65000);
      for (int k = 0; k < 4; k++) ends[k] = pick_label(base);
      send_request($urandom_range(0, 2) == 0, ends[0], ends[1]);
      maybe_gap(burst);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
